// ===== sv/chtb_pkg.sv =====
// Package for the coalesced hash table builder: request, result and table entry types,
// command and status codes, and default sizes. Used by every module of the block.
`default_nettype none

package chtb_pkg;

  localparam int MAX_SLOTS_DEF = 4096;
  localparam logic [3:0] SIZE_LOG2_RESET = 4'd12;

  localparam logic [1:0] CMD_PLACE = 2'd0;
  localparam logic [1:0] CMD_CHAIN = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_DEFERRED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_ZERO_OFF = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] hash;
    logic [31:0] string_offset;
    logic [15:0] class_index;
    logic [11:0] read_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] slot;
    logic [31:0] entry_offset;
    logic [15:0] entry_data;
    logic [11:0] entry_delta;
  } rsp_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] data;
    logic [11:0] delta;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/chtb_mem.sv =====
// Table memory of the hash table builder: one write port and one read port, read data
// registered. Depends on chtb_pkg for the entry type.
`default_nettype none

module chtb_mem #(
  parameter int DEPTH = chtb_pkg::MAX_SLOTS_DEF,
  parameter int AW    = 12
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire chtb_pkg::entry_t wdata,
  input  wire logic [AW-1:0]    raddr,
  output chtb_pkg::entry_t      rdata
);

  chtb_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/chtb_ctrl.sv =====
// Sequencer of the hash table builder: places, chains, reads and clears entries through
// the table memory one slot per cycle. Depends on chtb_pkg.
`default_nettype none

module chtb_ctrl #(
  parameter int DEPTH = chtb_pkg::MAX_SLOTS_DEF,
  parameter int AW    = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire chtb_pkg::req_t   req,
  input  wire logic [4:0]       lg_eff,
  output logic                  done,
  output chtb_pkg::rsp_t        rsp,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output chtb_pkg::entry_t      mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  wire chtb_pkg::entry_t mem_rdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_READ  = 7'b0000100,
    S_HOME  = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_PROBE = 7'b0100000,
    S_LINK  = 7'b1000000
  } state_t;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  state_t           state, state_next;
  logic [AW-1:0]    cur, cur_next;
  logic [AW:0]      steps, steps_next;
  logic [AW:0]      idx, idx_next;
  logic [1:0]       cmd_q;
  logic [31:0]      off_q;
  logic [15:0]      data_q;
  logic [AW-1:0]    home_q;
  logic [AW-1:0]    end_pos;
  chtb_pkg::entry_t end_word;
  logic             clr_report;
  logic             emit;
  chtb_pkg::rsp_t   rsp_next;
  logic             walk_more;

  logic [AW-1:0]    mask;
  logic [AW:0]      size;
  logic [AW-1:0]    home_in;
  logic [15:0]      data_in;
  logic             accept;

  assign mask    = ~({AW{1'b1}} << lg_eff);
  assign size    = {1'b0, mask} + {{AW{1'b0}}, 1'b1};
  assign home_in = AW'(req.hash) & mask;
  assign data_in = (req.hash[15:0] & (16'hFFFF << lg_eff)) | req.class_index;
  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);

  assign walk_more = (mem_rdata.delta != 12'd0) && (steps < size);
  assign mem_raddr = cur_next;

  always_comb begin
    state_next = state;
    cur_next   = cur;
    steps_next = steps;
    idx_next   = idx;
    mem_we     = 1'b0;
    mem_waddr  = cur;
    mem_wdata  = '0;
    emit       = 1'b0;
    rsp_next   = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (req.cmd)
            chtb_pkg::CMD_CLEAR: begin
              cur_next   = '0;
              state_next = S_CLEAR;
            end
            chtb_pkg::CMD_READ: begin
              cur_next   = AW'(req.read_index) & mask;
              state_next = S_READ;
            end
            chtb_pkg::CMD_PLACE, chtb_pkg::CMD_CHAIN: begin
              if (req.string_offset == 32'd0) begin
                emit            = 1'b1;
                rsp_next.status = chtb_pkg::ST_ZERO_OFF;
              end else begin
                cur_next   = home_in;
                state_next = S_HOME;
              end
            end
          endcase
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cur == LAST) begin
          state_next = S_IDLE;
          emit       = clr_report;
        end else begin
          cur_next = cur + {{(AW-1){1'b0}}, 1'b1};
        end
      end
      S_READ: begin
        emit                  = 1'b1;
        rsp_next.status       = chtb_pkg::ST_READ;
        rsp_next.slot         = 12'(cur);
        rsp_next.entry_offset = mem_rdata.offset;
        rsp_next.entry_data   = mem_rdata.data;
        rsp_next.entry_delta  = mem_rdata.delta;
        state_next            = S_IDLE;
      end
      S_HOME: begin
        if (mem_rdata.offset == 32'd0) begin
          mem_we           = 1'b1;
          mem_wdata.offset = off_q;
          mem_wdata.data   = data_q;
          emit             = 1'b1;
          rsp_next.status  = chtb_pkg::ST_DONE;
          rsp_next.slot    = 12'(cur);
          state_next       = S_IDLE;
        end else if (cmd_q == chtb_pkg::CMD_PLACE) begin
          emit            = 1'b1;
          rsp_next.status = chtb_pkg::ST_DEFERRED;
          rsp_next.slot   = 12'(cur);
          state_next      = S_IDLE;
        end else begin
          steps_next = '0;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        // The step count bounds the walk so that a looped chain still ends.
        if (walk_more) begin
          cur_next   = (cur + AW'(mem_rdata.delta)) & mask;
          steps_next = steps + {{AW{1'b0}}, 1'b1};
        end else begin
          cur_next   = (cur + {{(AW-1){1'b0}}, 1'b1}) & mask;
          idx_next   = {{AW{1'b0}}, 1'b1};
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (mem_rdata.offset == 32'd0) begin
          mem_we           = 1'b1;
          mem_wdata.offset = off_q;
          mem_wdata.data   = data_q;
          state_next       = S_LINK;
        end else if ((idx + {{AW{1'b0}}, 1'b1}) < size) begin
          idx_next = idx + {{AW{1'b0}}, 1'b1};
          cur_next = (cur + {{(AW-1){1'b0}}, 1'b1}) & mask;
        end else begin
          emit            = 1'b1;
          rsp_next.status = chtb_pkg::ST_FULL;
          rsp_next.slot   = 12'(home_q);
          state_next      = S_IDLE;
        end
      end
      S_LINK: begin
        // The old chain end keeps its contents and gains the link to the new slot.
        mem_we           = 1'b1;
        mem_waddr        = end_pos;
        mem_wdata.offset = end_word.offset;
        mem_wdata.data   = end_word.data;
        mem_wdata.delta  = 12'((cur - end_pos) & mask);
        emit             = 1'b1;
        rsp_next.status  = chtb_pkg::ST_DONE;
        rsp_next.slot    = 12'(cur);
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cur        <= '0;
      clr_report <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      done  <= emit;
      if (accept) begin
        clr_report <= (req.cmd == chtb_pkg::CMD_CLEAR);
      end
    end
  end

  always_ff @(posedge clk) begin
    steps <= steps_next;
    idx   <= idx_next;
    if (emit) begin
      rsp <= rsp_next;
    end
    if (accept) begin
      cmd_q  <= req.cmd;
      off_q  <= req.string_offset;
      data_q <= data_in;
      home_q <= home_in;
    end
    if ((state == S_WALK) && !walk_more) begin
      end_pos  <= cur;
      end_word <= mem_rdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/coalesced_hash_table_builder.sv =====
// Coalesced hash table builder. A request is taken when start is high and busy is low;
// each request gives exactly one result, shown for one cycle with done high, which the
// receiver cannot hold off. Timing is set by the table memory, read one slot per cycle:
// a chain insert walks the chain and then probes for a free slot, visiting up to about
// twice the table size in slots on a full table. Clearing sweeps every slot, and the
// same sweep runs silently after reset, during which busy stays high. Depends on
// chtb_pkg, chtb_ctrl and chtb_mem.
`default_nettype none

module coalesced_hash_table_builder #(
  parameter int MAX_SLOTS = chtb_pkg::MAX_SLOTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire chtb_pkg::req_t req,
  output logic                done,
  output chtb_pkg::rsp_t      rsp,
  input  wire logic           cfg_we,
  input  wire logic [3:0]     cfg_wdata
);

  localparam int AW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LG_MAX = $clog2(MAX_SLOTS + 1) - 1;

  logic [3:0]       table_size_log2;
  logic [4:0]       lg_eff;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  chtb_pkg::entry_t mem_wdata;
  chtb_pkg::entry_t mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size_log2 <= chtb_pkg::SIZE_LOG2_RESET;
    end else if (cfg_we) begin
      table_size_log2 <= cfg_wdata;
    end
  end

  // A size exponent of zero is taken as one, and the size never exceeds the memory depth.
  always_comb begin
    priority if (table_size_log2 == 4'd0) begin
      lg_eff = 5'd1;
    end else if ({1'b0, table_size_log2} > 5'(LG_MAX)) begin
      lg_eff = 5'(LG_MAX);
    end else begin
      lg_eff = {1'b0, table_size_log2};
    end
  end

  chtb_ctrl #(
    .DEPTH (MAX_SLOTS),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .lg_eff    (lg_eff),
    .done      (done),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  chtb_mem #(
    .DEPTH (MAX_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for coalesced_hash_table_builder: directed corner cases, then
// randomised table builds and random requests, checked against a shadow copy of the table.
// Depends on chtb_pkg and the RTL of the block only.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int REPORT_LIMIT = 10;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  chtb_pkg::req_t req;
  logic           done;
  chtb_pkg::rsp_t rsp;
  logic           cfg_we;
  logic [3:0]     cfg_wdata;

  // Shadow copy of the table and of the size register.
  logic [31:0] shadow_offset [chtb_pkg::MAX_SLOTS_DEF];
  logic [15:0] shadow_data   [chtb_pkg::MAX_SLOTS_DEF];
  logic [11:0] shadow_delta  [chtb_pkg::MAX_SLOTS_DEF];
  logic [3:0]  size_log2_shadow;

  chtb_pkg::rsp_t pending_results[$];
  int   error_count = 0;
  int   burst_left = 0;

  coalesced_hash_table_builder dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void wipe_shadow_table();
    for (int i = 0; i < chtb_pkg::MAX_SLOTS_DEF; i++) begin
      shadow_offset[i] = '0;
      shadow_data[i]   = '0;
      shadow_delta[i]  = '0;
    end
  endfunction

  function automatic void store_entry(logic [11:0] pos, logic [31:0] off, logic [15:0] word);
    shadow_offset[pos] = off;
    shadow_data[pos]   = word;
    shadow_delta[pos]  = '0;
  endfunction

  // Applies one request to the shadow table and returns the result it should give.
  function automatic chtb_pkg::rsp_t apply_table_request(chtb_pkg::req_t r);
    int unsigned    lg;
    int unsigned    slots;
    int unsigned    steps;
    int unsigned    i;
    logic [31:0]    mask;
    logic [31:0]    home;
    logic [31:0]    end_slot;
    logic [31:0]    probe;
    logic [15:0]    packed_word;
    bit             found;
    chtb_pkg::rsp_t res;
    lg = (size_log2_shadow == 4'd0) ? 32'd1 : 32'(size_log2_shadow);
    slots = 1 << lg;
    if (slots > chtb_pkg::MAX_SLOTS_DEF) slots = chtb_pkg::MAX_SLOTS_DEF;
    mask = slots - 1;
    home = r.hash & mask;
    packed_word = (r.hash[15:0] & ~mask[15:0]) | r.class_index;
    res = '0;
    if (r.cmd == chtb_pkg::CMD_CLEAR) begin
      wipe_shadow_table();
      res.status = chtb_pkg::ST_DONE;
    end else if (r.cmd == chtb_pkg::CMD_READ) begin
      probe = {20'd0, r.read_index} & mask;
      res.status       = chtb_pkg::ST_READ;
      res.slot         = probe[11:0];
      res.entry_offset = shadow_offset[probe[11:0]];
      res.entry_data   = shadow_data[probe[11:0]];
      res.entry_delta  = shadow_delta[probe[11:0]];
    end else if (r.string_offset == 32'd0) begin
      res.status = chtb_pkg::ST_ZERO_OFF;
    end else if (shadow_offset[home[11:0]] == 32'd0) begin
      store_entry(home[11:0], r.string_offset, packed_word);
      res.status = chtb_pkg::ST_DONE;
      res.slot   = home[11:0];
    end else if (r.cmd == chtb_pkg::CMD_PLACE) begin
      res.status = chtb_pkg::ST_DEFERRED;
      res.slot   = home[11:0];
    end else begin
      // The walk is bounded so that a looped chain still ends somewhere.
      end_slot = home;
      steps = 0;
      while (shadow_delta[end_slot[11:0]] != 12'd0 && steps < slots) begin
        end_slot = (end_slot + {20'd0, shadow_delta[end_slot[11:0]]}) & mask;
        steps++;
      end
      found = 1'b0;
      probe = end_slot;
      for (i = 1; i < slots && !found; i++) begin
        probe = (end_slot + i) & mask;
        found = (shadow_offset[probe[11:0]] == 32'd0);
      end
      if (!found) begin
        res.status = chtb_pkg::ST_FULL;
        res.slot   = home[11:0];
      end else begin
        shadow_delta[end_slot[11:0]] = 12'((probe - end_slot) & mask);
        store_entry(probe[11:0], r.string_offset, packed_word);
        res.status = chtb_pkg::ST_DONE;
        res.slot   = probe[11:0];
      end
    end
    return res;
  endfunction

  function automatic chtb_pkg::req_t make_request(logic [1:0] cmd, logic [31:0] hash,
                                                  logic [31:0] off, logic [15:0] cls,
                                                  logic [11:0] ridx);
    chtb_pkg::req_t r;
    r.cmd           = cmd;
    r.hash          = hash;
    r.string_offset = off;
    r.class_index   = cls;
    r.read_index    = ridx;
    return r;
  endfunction

  // Random fields; half the hashes share a few home slots so that chains form at any size.
  function automatic chtb_pkg::req_t random_request(logic [1:0] cmd);
    chtb_pkg::req_t r;
    r = make_request(cmd, $urandom(), $urandom(), 16'($urandom()), 12'($urandom()));
    if ($urandom_range(0, 1) == 0) r.hash[11:0] = 12'($urandom_range(0, 7));
    if ($urandom_range(0, 15) == 0) r.string_offset = '0;
    return r;
  endfunction

  // Called and returns at a falling edge; start is left high so that back-to-back
  // requests need no extra edge.
  task automatic send_request(input chtb_pkg::req_t item, output chtb_pkg::rsp_t predicted);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      burst_left = $urandom_range(8, 30);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = item;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predicted = apply_table_request(item);
    pending_results.insert(pending_results.size(), predicted);
    @(negedge clk);
  endtask

  // Holds requests off until every outstanding result has come and the block is idle.
  task automatic wait_idle();
    start = 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    @(negedge clk);
  endtask

  task automatic set_table_size(input logic [3:0] value);
    wait_idle();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    size_log2_shadow = value;
  endtask

  always @(posedge clk) begin : result_check
    chtb_pkg::rsp_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result: status %0d slot %0d offset %h data %h delta %0d",
                   rsp.status, rsp.slot, rsp.entry_offset, rsp.entry_data, rsp.entry_delta);
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status || rsp.slot !== want.slot ||
            rsp.entry_offset !== want.entry_offset || rsp.entry_data !== want.entry_data ||
            rsp.entry_delta !== want.entry_delta) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("mismatch: expected status %0d slot %0d offset %h data %h delta %0d, %s",
                     want.status, want.slot, want.entry_offset, want.entry_data,
                     want.entry_delta,
                     $sformatf("got status %0d slot %0d offset %h data %h delta %0d",
                               rsp.status, rsp.slot, rsp.entry_offset, rsp.entry_data,
                               rsp.entry_delta));
        end
      end
    end
  end

  // Full-size table: extreme field values, wrap of the probe, zero offsets and clearing.
  task automatic test_home_and_chain_basics();
    chtb_pkg::rsp_t got;
    set_table_size(4'd12);
    send_request(make_request(chtb_pkg::CMD_READ, '0, '0, '0, 12'hFFF), got);
    send_request(make_request(chtb_pkg::CMD_PLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                              '0), got);
    send_request(make_request(chtb_pkg::CMD_READ, '0, '0, '0, 12'hFFF), got);
    send_request(make_request(chtb_pkg::CMD_PLACE, 32'h0000_0FFF, 32'd1, 16'h0000, '0), got);
    // Chain end at the top slot, so the probe wraps round to slot zero.
    send_request(make_request(chtb_pkg::CMD_CHAIN, 32'hFFFF_FFFF, 32'd2, 16'h0000, '0), got);
    send_request(make_request(chtb_pkg::CMD_CHAIN, 32'h0000_0000, 32'd3, 16'h1234, '0), got);
    send_request(make_request(chtb_pkg::CMD_READ, '0, '0, '0, 12'hFFF), got);
    send_request(make_request(chtb_pkg::CMD_READ, '0, '0, '0, 12'h000), got);
    send_request(make_request(chtb_pkg::CMD_PLACE, 32'h0000_0010, 32'd0, 16'hFFFF, '0), got);
    send_request(make_request(chtb_pkg::CMD_CHAIN, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, '0), got);
    // Chain insert whose home slot is still free.
    send_request(make_request(chtb_pkg::CMD_CHAIN, 32'h00AB_C123, 32'h8000_0000, 16'h5A5A,
                              '0), got);
    send_request(make_request(chtb_pkg::CMD_CLEAR, '0, '0, '0, '0), got);
    send_request(make_request(chtb_pkg::CMD_READ, '0, '0, '0, 12'h123), got);
  endtask

  // Tiny tables: size register zero, a full table, read index wrap and a looped chain
  // left behind when the table shrinks without being cleared.
  task automatic test_small_table_corners();
    chtb_pkg::rsp_t got;
    set_table_size(4'd0);
    send_request(make_request(chtb_pkg::CMD_PLACE, 32'd0, 32'd5, 16'd1, '0), got);
    send_request(make_request(chtb_pkg::CMD_PLACE, 32'd1, 32'd6, 16'd2, '0), got);
    send_request(make_request(chtb_pkg::CMD_CHAIN, 32'd2, 32'd7, 16'd3, '0), got);
    send_request(make_request(chtb_pkg::CMD_READ, '0, '0, '0, 12'hFFF), got);
    send_request(make_request(chtb_pkg::CMD_CLEAR, '0, '0, '0, '0), got);
    set_table_size(4'd3);
    for (int h = 0; h < 4; h++)
      send_request(make_request(chtb_pkg::CMD_PLACE, h, 32'h100 + h, 16'h0010, '0), got);
    send_request(make_request(chtb_pkg::CMD_CHAIN, 32'd8, 32'h200, 16'h0020, '0), got);
    set_table_size(4'd2);
    send_request(make_request(chtb_pkg::CMD_CHAIN, 32'd0, 32'h300, 16'h0030, '0), got);
    send_request(make_request(chtb_pkg::CMD_READ, '0, '0, '0, 12'h000), got);
    send_request(make_request(chtb_pkg::CMD_CLEAR, '0, '0, '0, '0), got);
  endtask

  // Two-pass builds as a host would run them: place every key at home, then chain in
  // the deferred ones, then read some slots back.
  task automatic test_build_passes(input int item_budget);
    int             used;
    int             phase;
    int             n;
    int             pick;
    logic [3:0]     lg;
    chtb_pkg::req_t key;
    chtb_pkg::req_t deferred[$];
    chtb_pkg::rsp_t got;
    used = 0;
    phase = 0;
    while (used < item_budget) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) lg = 4'($urandom_range(1, 4));
      else if (pick <= 8) lg = 4'($urandom_range(5, 12));
      else begin
        lg = 4'($urandom_range(12, 15));
        if (lg == 4'd12) lg = 4'd0;
      end
      set_table_size(lg);
      if ($urandom_range(0, 1) == 0) begin
        send_request(make_request(chtb_pkg::CMD_CLEAR, $urandom(), $urandom(),
                                  16'($urandom()), 12'($urandom())), got);
        used++;
      end
      n = $urandom_range(2, 14);
      deferred.delete();
      for (int k = 0; k < n; k++) begin
        key = random_request(chtb_pkg::CMD_PLACE);
        send_request(key, got);
        used++;
        if (got.status == chtb_pkg::ST_DEFERRED) deferred.insert(deferred.size(), key);
      end
      if (phase == 0 || $urandom_range(0, 3) == 0) wait_idle();
      foreach (deferred[k]) begin
        key = deferred[k];
        key.cmd = chtb_pkg::CMD_CHAIN;
        send_request(key, got);
        used++;
      end
      repeat ($urandom_range(1, 4)) begin
        send_request(random_request(chtb_pkg::CMD_READ), got);
        used++;
      end
      phase++;
    end
  endtask

  task automatic test_random_requests(input int count);
    chtb_pkg::rsp_t got;
    for (int k = 0; k < count; k++) begin
      if (k % 25 == 0) set_table_size(4'($urandom_range(0, 15)));
      send_request(random_request(2'($urandom_range(0, 3))), got);
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    size_log2_shadow = chtb_pkg::SIZE_LOG2_RESET;
    wipe_shadow_table();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_home_and_chain_basics();
    test_small_table_corners();
    test_build_passes(430);
    test_random_requests(100);

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/chtb_pkg.sv
sv/chtb_mem.sv
sv/chtb_ctrl.sv
sv/coalesced_hash_table_builder.sv
tb/testbench.sv
